FILE: hdl/dpsp_pkg.sv
// ----------------------------------------------------------------------------
// dpsp_pkg
// Shared types, widths and constants of the dual pedal sensor plausibility
// block: transaction payloads, configuration set, queue entry and codes.
// ----------------------------------------------------------------------------
package dpsp_pkg;

  localparam int ADC_W      = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int PCT_FRAC   = 8;
  localparam int PCT_W      = PCT_FRAC + 7;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;
  localparam int PROD_W     = ADC_W + GAIN_W;
  localparam int SCALED_W   = PROD_W - GAIN_FRAC;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100 << PCT_FRAC);

  localparam int QUEUE_DEPTH = 4;

  // Register values after reset
  localparam logic [ADC_W-1:0]  RST_RELEASED_A = ADC_W'(702);
  localparam logic [GAIN_W-1:0] RST_GAIN_A     = GAIN_W'(29127);
  localparam logic [ADC_W-1:0]  RST_RELEASED_B = ADC_W'(701);
  localparam logic [GAIN_W-1:0] RST_GAIN_B     = GAIN_W'(29388);
  localparam logic [PCT_W-1:0]  RST_DEV_LIMIT  = PCT_W'(2560);
  localparam logic [TMO_W-1:0]  RST_TIMEOUT    = TMO_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASED_A = 3'd0,
    CFG_GAIN_A     = 3'd1,
    CFG_RELEASED_B = 3'd2,
    CFG_GAIN_B     = 3'd3,
    CFG_DEV_LIMIT  = 3'd4,
    CFG_TIMEOUT    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_HOLD  = 2'd1,
    ST_FAULT = 2'd2
  } status_e;

  typedef enum logic {
    TMR_IDLE = 1'b0,
    TMR_RUN  = 1'b1
  } timer_e;

  typedef struct packed {
    logic [ADC_W-1:0]  raw_a;
    logic [ADC_W-1:0]  raw_b;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] pedal_percent;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    logic [ADC_W-1:0]  released_raw_a;
    logic [GAIN_W-1:0] gain_a;
    logic [ADC_W-1:0]  released_raw_b;
    logic [GAIN_W-1:0] gain_b;
    logic [PCT_W-1:0]  deviation_limit;
    logic [TMO_W-1:0]  timeout_ms;
  } cfg_t;

  // Classified sample pair, as queued between front and back
  typedef struct packed {
    logic              implausible;
    logic [PCT_W-1:0]  avg;
    logic [TIME_W-1:0] now_ms;
  } cls_item_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } front_status_t;

endpackage

FILE: hdl/dpsp_front.sv
// ----------------------------------------------------------------------------
// dpsp_front
// Front pipeline: scale both samples to percent, clamp, then classify the
// pair as plausible or not and push it into the queue.
// ----------------------------------------------------------------------------
module dpsp_front import dpsp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  in_item_t      in_data_i,
  input  cfg_t          cfg_i,
  output front_status_t status_o,
  output logic          push_o,
  output cls_item_t     push_data_o
);

  logic                s1_valid_q;
  logic [PROD_W-1:0]   prod_a_q, prod_b_q;
  logic [TIME_W-1:0]   now1_q;
  logic                s2_valid_q;
  logic [PCT_W-1:0]    pct_a_q, pct_b_q;
  logic [TIME_W-1:0]   now2_q;

  logic [ADC_W-1:0]    span_a, span_b;
  logic [PCT_W-1:0]    pct_a_d, pct_b_d;
  logic [PCT_W-1:0]    dev;
  logic [PCT_W:0]      sum;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PROD_W-1:0] prod);
    logic [SCALED_W-1:0] scaled;
    scaled = prod[PROD_W-1:GAIN_FRAC];
    if (scaled > SCALED_W'(PCT_FULL)) begin
      return PCT_FULL;
    end
    return scaled[PCT_W-1:0];
  endfunction

  // Negative span clamps to zero percent
  assign span_a = (in_data_i.raw_a < cfg_i.released_raw_a) ?
                  cfg_i.released_raw_a - in_data_i.raw_a : '0;
  assign span_b = (in_data_i.raw_b < cfg_i.released_raw_b) ?
                  cfg_i.released_raw_b - in_data_i.raw_b : '0;

  assign pct_a_d = clamp_pct(prod_a_q);
  assign pct_b_d = clamp_pct(prod_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      prod_a_q <= PROD_W'(span_a) * PROD_W'(cfg_i.gain_a);
      prod_b_q <= PROD_W'(span_b) * PROD_W'(cfg_i.gain_b);
      now1_q   <= in_data_i.now_ms;
    end
    if (s1_valid_q) begin
      pct_a_q <= pct_a_d;
      pct_b_q <= pct_b_d;
      now2_q  <= now1_q;
    end
  end

  // Classify: strictly greater than the limit is implausible
  assign dev = (pct_a_q > pct_b_q) ? pct_a_q - pct_b_q : pct_b_q - pct_a_q;
  assign sum = {1'b0, pct_a_q} + {1'b0, pct_b_q};

  assign push_o                  = s2_valid_q;
  assign push_data_o.implausible = dev > cfg_i.deviation_limit;
  assign push_data_o.avg         = sum[PCT_W:1];
  assign push_data_o.now_ms      = now2_q;

  assign status_o.s1_valid = s1_valid_q;
  assign status_o.s2_valid = s2_valid_q;

endmodule

FILE: hdl/dpsp_queue.sv
// ----------------------------------------------------------------------------
// dpsp_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dpsp_queue import dpsp_pkg::*; #(
  parameter int FIFO_DEPTH = QUEUE_DEPTH,
  parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cls_item_t        push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output cls_item_t        data_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  cls_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: hdl/dpsp_back.sv
// ----------------------------------------------------------------------------
// dpsp_back
// Back end: implausibility timer, last good position and the output register.
// ----------------------------------------------------------------------------
module dpsp_back import dpsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cls_item_t        q_data_i,
  input  logic [TMO_W-1:0] timeout_ms_i,
  input  logic             out_stall_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output out_item_t        out_data_o
);

  timer_e            timer_q, timer_d;
  logic [TIME_W-1:0] start_time_q, start_time_d;
  logic [PCT_W-1:0]  last_good_q, last_good_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic [TIME_W-1:0] elapsed;

  // Take a queued item whenever the output register is free or being drained
  assign pop_o   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign elapsed = q_data_i.now_ms - start_time_q;

  always_comb begin
    timer_d = timer_q;
    if (pop_o) begin
      timer_d = q_data_i.implausible ? TMR_RUN : TMR_IDLE;
    end
  end

  always_comb begin
    start_time_d = start_time_q;
    last_good_d  = last_good_q;
    out_d        = out_q;
    out_valid_d  = out_stall_i ? out_valid_q : 1'b0;
    if (pop_o) begin
      out_valid_d = 1'b1;
      if (!q_data_i.implausible) begin
        last_good_d         = q_data_i.avg;
        out_d.pedal_percent = q_data_i.avg;
        out_d.status        = ST_OK;
      end else begin
        out_d.pedal_percent = last_good_q;
        out_d.status        = ST_HOLD;
        case (timer_q)
          TMR_IDLE: begin
            start_time_d = q_data_i.now_ms;
          end
          TMR_RUN: begin
            if (elapsed > TIME_W'(timeout_ms_i)) begin
              out_d.pedal_percent = '0;
              out_d.status        = ST_FAULT;
            end
          end
          default: begin
            start_time_d = q_data_i.now_ms;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q      <= TMR_IDLE;
      start_time_q <= '0;
      last_good_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      timer_q      <= timer_d;
      start_time_q <= start_time_d;
      last_good_q  <= last_good_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/dual_pedal_sensor_plausibility.sv
// ----------------------------------------------------------------------------
// dual_pedal_sensor_plausibility
// Cross-checks two redundant pedal sensors and reports position and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one sample
//   pair plus a millisecond timestamp per transaction. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one position and status
//   per input transaction, in order.
//   Configuration: pulse cfg_we_i with cfg_idx_i and cfg_wdata_i while the
//   block is idle; indexes beyond the register list are ignored.
//   Path: multiply register, clamp register, classify into the queue, then
//   timer update into the output register.
//   Throughput: one transaction per cycle while in_stall_o is low, set by
//   the single 12x16 multiplier stage per sensor and the back-end timer update.
//   When the receiver stalls, the output register holds, the queue fills and
//   in_stall_o rises once queue plus in-flight front items reach FIFO_DEPTH.
//   Reset clears the timer, the last good position, all valid flags and loads
//   the default calibration.
// ----------------------------------------------------------------------------
module dual_pedal_sensor_plausibility import dpsp_pkg::*; #(
  parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W = CNT_W + 1;

  cfg_t             cfg_q, cfg_d;
  front_status_t    front_status;
  logic             take;
  logic             push;
  cls_item_t        push_data;
  logic             q_valid;
  cls_item_t        q_data;
  logic             pop;
  logic [CNT_W-1:0] q_count;
  logic [OCC_W-1:0] occupancy;

  // Configuration registers; unknown indexes drop the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RELEASED_A: cfg_d.released_raw_a  = cfg_wdata_i[ADC_W-1:0];
        CFG_GAIN_A:     cfg_d.gain_a          = cfg_wdata_i[GAIN_W-1:0];
        CFG_RELEASED_B: cfg_d.released_raw_b  = cfg_wdata_i[ADC_W-1:0];
        CFG_GAIN_B:     cfg_d.gain_b          = cfg_wdata_i[GAIN_W-1:0];
        CFG_DEV_LIMIT:  cfg_d.deviation_limit = cfg_wdata_i[PCT_W-1:0];
        CFG_TIMEOUT:    cfg_d.timeout_ms      = cfg_wdata_i[TMO_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.released_raw_a  <= RST_RELEASED_A;
      cfg_q.gain_a          <= RST_GAIN_A;
      cfg_q.released_raw_b  <= RST_RELEASED_B;
      cfg_q.gain_b          <= RST_GAIN_B;
      cfg_q.deviation_limit <= RST_DEV_LIMIT;
      cfg_q.timeout_ms      <= RST_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Credit check: the front pipeline never stalls, so admit a transaction
  // only while the queue has room for everything already in flight.
  assign occupancy = OCC_W'(q_count) + OCC_W'(front_status.s1_valid)
                   + OCC_W'(front_status.s2_valid);
  assign in_stall_o = occupancy >= OCC_W'(FIFO_DEPTH);
  assign take       = in_valid_i && !in_stall_o;

  dpsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .status_o    (front_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dpsp_queue #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .CNT_W      (CNT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  dpsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .timeout_ms_i (cfg_q.timeout_ms),
    .out_stall_i  (out_stall_i),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // Credits keep queue plus front pipeline within the queue depth
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= OCC_W'(FIFO_DEPTH))
    else $error("queue occupancy exceeds depth");

  // A push never lands on a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count < CNT_W'(FIFO_DEPTH)) || pop)
    else $error("push into full queue");

  // A fault always reports zero position
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FAULT) |-> out_data_o.pedal_percent == '0)
    else $error("fault with nonzero position");

  // Reported position never exceeds full scale
  a_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pedal_percent <= PCT_FULL)
    else $error("position beyond full scale");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dual_pedal_sensor_plausibility. A queue-fed driver
// sends sample pairs with timestamps. A bit-exact predictor of the position
// mapping, the plausibility timer and the last good value computes each
// expected result. A monitor compares every output transaction against it.
// ----------------------------------------------------------------------------
module testbench import dpsp_pkg::*;;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 10;
  localparam int RUN_LIMIT     = 400000;
  localparam int RANDOM_ITEMS  = 92;   // per random phase, six phases

  // Index past the register list; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  dual_pedal_sensor_plausibility i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample pairs waiting to be sent, and positions/statuses still owed by the block
  in_item_t  sample_q[$];
  out_item_t pedal_result_q[$];

  // Idle percentages, changed by the sequencer between phases
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;

  // Predictor copy of the calibration registers and the plausibility state
  cfg_t                cal = '{
    released_raw_a:  RST_RELEASED_A,
    gain_a:          RST_GAIN_A,
    released_raw_b:  RST_RELEASED_B,
    gain_b:          RST_GAIN_B,
    deviation_limit: RST_DEV_LIMIT,
    timeout_ms:      RST_TIMEOUT
  };
  timer_e              timer_state    = TMR_IDLE;
  logic [TIME_W-1:0]   timer_start_ms = '0;
  logic [PCT_W-1:0]    last_good_pct  = '0;

  // Running timestamp for generated sample pairs; wraps naturally
  logic [TIME_W-1:0]   stamp_ms       = '0;

  // --------------------------------------------------------------------------
  // Position mapping: inverted, scaled by a Q8.8 gain, clamped to full scale.
  // A sample at or above the released reading maps to zero.
  // --------------------------------------------------------------------------
  function automatic logic [PCT_W-1:0] sensor_position(logic [ADC_W-1:0]  raw,
                                                       logic [ADC_W-1:0]  released,
                                                       logic [GAIN_W-1:0] gain);
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    if (raw >= released) return '0;
    prod   = PROD_W'(released - raw) * PROD_W'(gain);
    scaled = SCALED_W'(prod >> GAIN_FRAC);
    if (scaled > SCALED_W'(PCT_FULL)) return PCT_FULL;
    return scaled[PCT_W-1:0];
  endfunction

  function automatic logic [PCT_W-1:0] position_gap(logic [PCT_W-1:0] pa,
                                                    logic [PCT_W-1:0] pb);
    return (pa > pb) ? pa - pb : pb - pa;
  endfunction

  function automatic bit pair_agrees(in_item_t item);
    return position_gap(sensor_position(item.raw_a, cal.released_raw_a, cal.gain_a),
                        sensor_position(item.raw_b, cal.released_raw_b, cal.gain_b))
           <= cal.deviation_limit;
  endfunction

  // --------------------------------------------------------------------------
  // Plausibility step: a gap above the limit starts or checks the timer,
  // holding the last good position until the elapsed time strictly exceeds
  // the timeout. A fault does not clear the timer; only an agreeing pair does.
  // --------------------------------------------------------------------------
  function automatic out_item_t plausibility_step(in_item_t item);
    out_item_t         res;
    logic [PCT_W-1:0]  pa;
    logic [PCT_W-1:0]  pb;
    logic [PCT_W:0]    sum;
    logic [TIME_W-1:0] elapsed;
    pa = sensor_position(item.raw_a, cal.released_raw_a, cal.gain_a);
    pb = sensor_position(item.raw_b, cal.released_raw_b, cal.gain_b);
    if (position_gap(pa, pb) > cal.deviation_limit) begin
      elapsed = item.now_ms - timer_start_ms;
      if (timer_state == TMR_IDLE) begin
        timer_state       = TMR_RUN;
        timer_start_ms    = item.now_ms;
        res.pedal_percent = last_good_pct;
        res.status        = ST_HOLD;
      end else if (elapsed > TIME_W'(cal.timeout_ms)) begin
        res.pedal_percent = '0;
        res.status        = ST_FAULT;
      end else begin
        res.pedal_percent = last_good_pct;
        res.status        = ST_HOLD;
      end
    end else begin
      timer_state       = TMR_IDLE;
      sum               = {1'b0, pa} + {1'b0, pb};
      last_good_pct     = sum[PCT_W:1];
      res.pedal_percent = last_good_pct;
      res.status        = ST_OK;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: on acceptance, predict the result; then present the next sample
  // pair or drop valid for an idle cycle. A stalled payload stays put.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pedal_result_q.push_back(plausibility_step(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each output transaction against the oldest expectation,
  // then decide whether to stall the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pedal_result_q.size() == 0) begin
          $error("unexpected output transaction: pedal_percent %0d status %0d",
                 out_data_o.pedal_percent, out_data_o.status);
          fail_count++;
        end else begin
          want = pedal_result_q.pop_front();
          if (out_data_o.pedal_percent !== want.pedal_percent) begin
            $error("pedal_percent: expected %0d, actual %0d",
                   want.pedal_percent, out_data_o.pedal_percent);
            fail_count++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Write one register and mirror it into the predictor, truncated to width
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_RELEASED_A: cal.released_raw_a  = value[ADC_W-1:0];
      CFG_GAIN_A:     cal.gain_a          = value[GAIN_W-1:0];
      CFG_RELEASED_B: cal.released_raw_b  = value[ADC_W-1:0];
      CFG_GAIN_B:     cal.gain_b          = value[GAIN_W-1:0];
      CFG_DEV_LIMIT:  cal.deviation_limit = value[PCT_W-1:0];
      CFG_TIMEOUT:    cal.timeout_ms      = value[TMO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_calibration(logic [CFG_DATA_W-1:0] rel_a,
                                     logic [CFG_DATA_W-1:0] gain_a,
                                     logic [CFG_DATA_W-1:0] rel_b,
                                     logic [CFG_DATA_W-1:0] gain_b,
                                     logic [CFG_DATA_W-1:0] limit,
                                     logic [CFG_DATA_W-1:0] timeout);
    write_reg(CFG_RELEASED_A, rel_a);
    write_reg(CFG_GAIN_A,     gain_a);
    write_reg(CFG_RELEASED_B, rel_b);
    write_reg(CFG_GAIN_B,     gain_b);
    write_reg(CFG_DEV_LIMIT,  limit);
    write_reg(CFG_TIMEOUT,    timeout);
  endtask

  // Hold until every sample pair is sent and every result has come back
  task automatic drain();
    while (sample_q.size() != 0 || in_valid_i || pedal_result_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic push_pair(logic [ADC_W-1:0] ra, logic [ADC_W-1:0] rb,
                           logic [TIME_W-1:0] now);
    in_item_t item;
    item.raw_a  = ra;
    item.raw_b  = rb;
    item.now_ms = now;
    sample_q.push_back(item);
  endtask

  // Sample mostly within the active travel, full range now and then
  function automatic logic [ADC_W-1:0] travel_sample(logic [ADC_W-1:0] released);
    if (released != 0 && $urandom_range(9) != 0) return ADC_W'($urandom_range(released));
    return ADC_W'($urandom_range(4095));
  endfunction

  // Sample pair whose positions agree: invert B's mapping onto A's position
  function automatic in_item_t agreeing_pair();
    in_item_t item;
    int       need;
    int       rb;
    int       tries;
    item.now_ms = stamp_ms;
    for (tries = 0; tries < 8; tries++) begin
      item.raw_a = travel_sample(cal.released_raw_a);
      if (cal.gain_b == 0) begin
        rb = $urandom_range(4095);
      end else begin
        need = (int'(sensor_position(item.raw_a, cal.released_raw_a, cal.gain_a)) * 256
                + int'(cal.gain_b) - 1) / int'(cal.gain_b);
        rb   = int'(cal.released_raw_b) - need + int'($urandom_range(4)) - 2;
      end
      if (rb < 0) rb = 0;
      if (rb > 4095) rb = 4095;
      item.raw_b = ADC_W'(rb);
      if (pair_agrees(item)) break;
    end
    return item;
  endfunction

  function automatic in_item_t disagreeing_pair();
    in_item_t item;
    int       tries;
    item.now_ms = stamp_ms;
    for (tries = 0; tries < 8; tries++) begin
      item.raw_a = travel_sample(cal.released_raw_a);
      item.raw_b = travel_sample(cal.released_raw_b);
      if (!pair_agrees(item)) break;
    end
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic: mostly episodes of agreeing samples followed by a
  // disagreeing burst whose timestamps walk toward and past the timeout,
  // sometimes landing exactly on it and one past it. The rest is noise with
  // arbitrary samples and timestamps, which also sends time backwards.
  // --------------------------------------------------------------------------
  task automatic random_traffic(int count);
    int                sent;
    int                n_ok;
    int                n_bad;
    int                i;
    bit                hit_edge;
    logic [TIME_W-1:0] burst_start;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        push_pair(ADC_W'($urandom_range(4095)), ADC_W'($urandom_range(4095)), $urandom);
        sent++;
      end else begin
        n_ok     = $urandom_range(1, 5);
        hit_edge = ($urandom_range(2) == 0);
        n_bad    = hit_edge ? $urandom_range(3, 8) : $urandom_range(1, 8);
        for (i = 0; i < n_ok; i++) begin
          stamp_ms += $urandom_range(1, 20);
          sample_q.push_back(agreeing_pair());
        end
        stamp_ms   += $urandom_range(1, 20);
        burst_start = stamp_ms;
        for (i = 0; i < n_bad; i++) begin
          if (hit_edge && i == n_bad - 2) begin
            stamp_ms = burst_start + TIME_W'(cal.timeout_ms);
          end else if (hit_edge && i == n_bad - 1) begin
            stamp_ms = burst_start + TIME_W'(cal.timeout_ms) + 1;
          end else if (i > 0) begin
            stamp_ms += $urandom_range(0, cal.timeout_ms / 3 + 1);
          end
          sample_q.push_back(disagreeing_pair());
        end
        sent += n_ok + n_bad;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencer: reset, directed corner cases at the reset calibration, then
  // six random phases with different calibrations and idle patterns.
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 14;
    recv_stall_pct = 72;

    // Directed: reset calibration, released A=702 B=701, limit 2560, timeout 100
    push_pair(12'd4095, 12'd4095, 32'd0);           // above released: clamp to zero
    push_pair(12'd0,    12'd0,    32'd1);           // saturate at full scale
    push_pair(12'd702,  12'd701,  32'd2);           // exactly at released
    push_pair(12'd590,  12'd589,  32'd3);           // mid travel, agreeing
    push_pair(12'd590,  12'd701,  32'd1000);        // first disagreement: start timer
    push_pair(12'd590,  12'd701,  32'd1050);        // still holding
    push_pair(12'd590,  12'd701,  32'd1100);        // elapsed equals timeout: hold
    push_pair(12'd590,  12'd701,  32'd1101);        // one past timeout: fault
    push_pair(12'd590,  12'd701,  32'd5000);        // fault persists
    push_pair(12'd600,  12'd599,  32'd5001);        // agreement clears the timer
    push_pair(12'd0,    12'd701,  32'hFFFF_FFF0);   // timer starts near wrap
    push_pair(12'd0,    12'd701,  32'h0000_0050);   // wrapped elapsed within timeout
    push_pair(12'd0,    12'd701,  32'h0000_0055);   // wrapped elapsed past timeout
    push_pair(12'd477,  12'd478,  32'h0000_0060);   // agreeing near full scale
    push_pair(12'd701,  12'd0,    32'd1000);        // restart timer
    push_pair(12'd701,  12'd0,    32'd900);         // time goes backwards: fault
    push_pair(12'hAAA,  12'h555,  32'hFFFF_FFFF);   // both above released
    push_pair(12'h555,  12'hAAA,  32'h5555_5555);
    push_pair(12'd650,  12'd651,  32'hAAAA_AAAA);
    drain();

    // All registers, reset values written back explicitly
    program_calibration(16'(RST_RELEASED_A), 16'(RST_GAIN_A), 16'(RST_RELEASED_B),
                        16'(RST_GAIN_B), 16'(RST_DEV_LIMIT), 16'(RST_TIMEOUT));
    random_traffic(RANDOM_ITEMS);
    drain();

    // Upper extremes, bits above each register width dropped; spare index ignored
    program_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_SPARE_IDX, 16'h0000);
    random_traffic(RANDOM_ITEMS);
    drain();

    send_gap_pct   = 72;
    recv_stall_pct = 14;

    // Lower extremes: A pinned at zero, B steep, zero limit, zero timeout
    program_calibration(16'd0, 16'd0, 16'd4095, 16'hFFFF, 16'd0, 16'd0);
    random_traffic(RANDOM_ITEMS);
    drain();

    // Gap reaches the limit exactly at full scale on B
    program_calibration(16'd3000, 16'd0, 16'd4095, 16'hFFFF, 16'd25600, 16'd1);
    random_traffic(RANDOM_ITEMS);
    drain();

    send_gap_pct   = 0;
    recv_stall_pct = 0;

    // Plausible calibrations with short timeouts
    program_calibration(16'($urandom_range(1024, 4095)), 16'($urandom_range(65535)),
                        16'($urandom_range(1024, 4095)), 16'($urandom_range(65535)),
                        16'($urandom_range(6000)), 16'($urandom_range(200)));
    write_reg(CFG_SPARE_IDX, 16'($urandom));
    random_traffic(RANDOM_ITEMS);
    drain();

    // Anything goes
    program_calibration(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(25600)), 16'($urandom_range(1000)));
    random_traffic(RANDOM_ITEMS);
    drain();

    // Catch any stray output after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pedal_result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #RUN_LIMIT;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dpsp_pkg.sv
hdl/dpsp_front.sv
hdl/dpsp_queue.sv
hdl/dpsp_back.sv
hdl/dual_pedal_sensor_plausibility.sv
bench/testbench.sv
